// ----- rtl/core/qdp_pkg.sv -----
// Shared types, constants and helper function of the quantized dot-product block.
package qdp_pkg;

    // Width of the block integer sum as carried to the float unit (covers 256-element blocks)
    localparam int FSUM_W = 24;

    // Weight format codes
    localparam logic FMT_Q8_0 = 1'b0;
    localparam logic FMT_Q4_0 = 1'b1;

    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

    // Block close request from the merge stage to the float unit
    typedef struct packed {
        logic                     start;
        logic signed [FSUM_W-1:0] sum;
        logic [15:0]              ws;
        logic [31:0]              as_bits;
        logic                     last;
    } qdp_close_t;

    // Row result from the float unit
    typedef struct packed {
        logic        valid;
        logic [31:0] data;
    } qdp_res_t;

    // Leading-zero count of a 52-bit word (52 when the word is zero)
    function automatic logic [5:0] lzc52(input logic [51:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd52;
        found = 1'b0;
        for (int i = 51; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(51 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/qdp_lane.sv -----
// One lane: weight decode and signed weight times activation product.
module qdp_lane (
    input  logic               fmt,
    input  logic [7:0]         w_code,
    input  logic [7:0]         a_code,
    output logic signed [15:0] prod
);
    import qdp_pkg::*;

    logic signed [8:0]  w_val;
    logic signed [16:0] prod_full;

    // Q4_0: low nibble minus eight; Q8_0: signed byte
    assign w_val = (fmt == FMT_Q4_0) ? ($signed({5'd0, w_code[3:0]}) - 9'sd8)
                                     : $signed({w_code[7], w_code});
    assign prod_full = w_val * $signed(a_code);
    assign prod      = prod_full[15:0];

endmodule

// ----- rtl/core/qdp_merge.sv -----
// Merge stage: sum the lane products, accumulate the block sum, close blocks.
module qdp_merge #(
    parameter int LANES       = 8,
    parameter int BLOCK_ELEMS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [15:0] lane_prod [LANES],
    input  logic [15:0]        weight_scale,
    input  logic [31:0]        act_scale,
    input  logic               row_end,
    output qdp_pkg::qdp_close_t req
);
    import qdp_pkg::*;

    localparam int PER_BLOCK = (BLOCK_ELEMS / LANES < 1) ? 1 : BLOCK_ELEMS / LANES;
    localparam int CNT_W     = $clog2(PER_BLOCK + 1);
    localparam int SUM_W     = 16 + $clog2(BLOCK_ELEMS);
    localparam int ISUM_W    = 16 + $clog2(LANES);

    logic signed [ISUM_W-1:0] item_sum;
    logic signed [SUM_W-1:0]  blk_sum;
    logic signed [SUM_W-1:0]  blk_reg, blk_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     close;
    qdp_close_t               req_reg, req_next;

    always_comb begin
        item_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            item_sum = item_sum + ISUM_W'(lane_prod[l]);
        end
    end

    assign blk_sum = blk_reg + SUM_W'(item_sum);
    assign close   = (cnt_reg == CNT_W'(PER_BLOCK - 1)) || row_end;

    always_comb begin
        blk_next      = blk_reg;
        cnt_next      = cnt_reg;
        req_next      = req_reg;
        req_next.start = 1'b0;
        if (accept) begin
            if (close) begin
                blk_next         = '0;
                cnt_next         = '0;
                req_next.start   = 1'b1;
                req_next.sum     = FSUM_W'(blk_sum);
                req_next.ws      = weight_scale;
                req_next.as_bits = act_scale;
                req_next.last    = row_end;
            end else begin
                blk_next = blk_sum;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            blk_reg <= '0;
            cnt_reg <= '0;
            req_reg <= '0;
        end else begin
            blk_reg <= blk_next;
            cnt_reg <= cnt_next;
            req_reg <= req_next;
        end
    end

    assign req = req_reg;

endmodule

// ----- rtl/core/qdp_fpu.sv -----
// Float unit: block scale product and fused multiply-add into the row accumulator.
module qdp_fpu (
    input  logic                clk,
    input  logic                rst_n,
    input  qdp_pkg::qdp_close_t req,
    input  logic                res_take,
    output logic                busy,
    output qdp_pkg::qdp_res_t   res
);
    import qdp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SMUL  = 9'b000000010,
        ST_RNORM = 9'b000000100,
        ST_RPACK = 9'b000001000,
        ST_PMUL  = 9'b000010000,
        ST_PNORM = 9'b000100000,
        ST_ALIGN = 9'b001000000,
        ST_ADD   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } fpu_state_t;

    fpu_state_t               state_reg, state_next;
    logic signed [FSUM_W-1:0] sum_reg, sum_next;
    logic [15:0]              ws_reg, ws_next;
    logic [31:0]              as_reg, as_next;
    logic                     last_reg, last_next;
    logic [31:0]              scale_reg, scale_next;
    logic [31:0]              acc_reg, acc_next;
    logic [51:0]              rm_reg, rm_next;
    logic signed [10:0]       rx_reg, rx_next;
    logic                     rsg_reg, rsg_next;
    logic                     phase_reg, phase_next;
    logic signed [10:0]       sh_reg, sh_next;
    logic signed [10:0]       eb_reg, eb_next;
    logic [47:0]              mp_reg, mp_next;
    logic [47:0]              ma_reg, ma_next;
    logic signed [10:0]       ep_reg, ep_next;
    logic signed [10:0]       tp_reg, tp_next;
    logic signed [10:0]       ta_reg, ta_next;
    logic                     sp_reg, sp_next;
    logic                     pz_reg, pz_next;
    logic                     az_reg, az_next;
    logic [51:0]              xb_reg, xb_next;
    logic [51:0]              xs_reg, xs_next;
    logic signed [10:0]       tb_reg, tb_next;
    logic                     bsg_reg, bsg_next;
    logic                     sub_reg, sub_next;

    // Operand decode
    logic [4:0]         h_exp;
    logic [9:0]         h_man;
    logic [7:0]         f_exp, c_exp, a_exp;
    logic [22:0]        f_man, c_man, a_man;
    logic               h_nan, h_inf, h_zero, f_nan, f_inf, f_zero;
    logic               c_nan, c_inf, c_zero, a_nan, a_inf, a_zero;
    logic [10:0]        h_sig;
    logic [23:0]        f_sig, c_sig, a_sig;
    logic signed [10:0] h_eff, f_eff, c_eff, a_eff;
    logic [23:0]        sum_mag;
    logic [34:0]        s_prod;
    logic [47:0]        p_prod;
    logic               fin_idle;

    assign h_exp  = ws_reg[14:10];
    assign h_man  = ws_reg[9:0];
    assign f_exp  = as_reg[30:23];
    assign f_man  = as_reg[22:0];
    assign c_exp  = scale_reg[30:23];
    assign c_man  = scale_reg[22:0];
    assign a_exp  = acc_reg[30:23];
    assign a_man  = acc_reg[22:0];
    assign h_nan  = (h_exp == 5'h1F) && (h_man != 10'd0);
    assign h_inf  = (h_exp == 5'h1F) && (h_man == 10'd0);
    assign h_zero = (h_exp == 5'd0) && (h_man == 10'd0);
    assign f_nan  = (f_exp == 8'hFF) && (f_man != 23'd0);
    assign f_inf  = (f_exp == 8'hFF) && (f_man == 23'd0);
    assign f_zero = (f_exp == 8'd0) && (f_man == 23'd0);
    assign c_nan  = (c_exp == 8'hFF) && (c_man != 23'd0);
    assign c_inf  = (c_exp == 8'hFF) && (c_man == 23'd0);
    assign c_zero = (c_exp == 8'd0) && (c_man == 23'd0);
    assign a_nan  = (a_exp == 8'hFF) && (a_man != 23'd0);
    assign a_inf  = (a_exp == 8'hFF) && (a_man == 23'd0);
    assign a_zero = (a_exp == 8'd0) && (a_man == 23'd0);
    assign h_sig  = {h_exp != 5'd0, h_man};
    assign f_sig  = {f_exp != 8'd0, f_man};
    assign c_sig  = {c_exp != 8'd0, c_man};
    assign a_sig  = {a_exp != 8'd0, a_man};
    assign h_eff  = (h_exp == 5'd0) ? 11'sd1 : $signed({6'd0, h_exp});
    assign f_eff  = (f_exp == 8'd0) ? 11'sd1 : $signed({3'd0, f_exp});
    assign c_eff  = (c_exp == 8'd0) ? 11'sd1 : $signed({3'd0, c_exp});
    assign a_eff  = (a_exp == 8'd0) ? 11'sd1 : $signed({3'd0, a_exp});
    assign sum_mag = sum_reg[FSUM_W-1] ? 24'(-sum_reg) : 24'(sum_reg);
    assign s_prod  = h_sig * f_sig;
    assign p_prod  = sum_mag * c_sig;

    // Operand normalization (PNORM)
    logic [5:0]         lzp, lza;
    logic [47:0]        a_sig48;
    logic signed [10:0] tp_calc, ta_calc;

    assign a_sig48 = {24'd0, a_sig};
    assign lzp     = lzc52({mp_reg, 4'd0});
    assign lza     = lzc52({a_sig48, 4'd0});
    assign tp_calc = ep_reg + 11'sd47 - $signed({5'd0, lzp});
    assign ta_calc = a_eff - 11'sd103 - $signed({5'd0, lza});

    // Alignment (ALIGN)
    logic               bigp;
    logic signed [10:0] d_exp;
    logic [47:0]        m_big, m_small;
    logic [51:0]        xs_full, xs_calc;
    logic [5:0]         dsh;

    assign bigp    = az_reg || (tp_reg > ta_reg) || ((tp_reg == ta_reg) && (mp_reg >= ma_reg));
    assign m_big   = bigp ? mp_reg : ma_reg;
    assign m_small = bigp ? ma_reg : mp_reg;
    assign d_exp   = bigp ? (tp_reg - ta_reg) : (ta_reg - tp_reg);
    assign xs_full = {1'b0, m_small, 3'd0};
    assign dsh     = d_exp[5:0];

    always_comb begin
        if (az_reg) begin
            xs_calc = '0;
        end else if (d_exp >= 11'sd52) begin
            xs_calc = 52'd1;
        end else begin
            xs_calc = (xs_full >> dsh)
                    | 52'((xs_full & ((52'd1 << dsh) - 52'd1)) != 52'd0);
        end
    end

    // Rounding: find the leading one (RNORM), shift and round (RPACK)
    logic [5:0]         lz_r;
    logic signed [10:0] q_pos, eu;
    logic [5:0]         shu;
    logic [25:0]        mr, mrr;
    logic               g_bit, st_bit;
    logic [33:0]        tot;
    logic [31:0]        pack_bits;

    assign lz_r  = lzc52(rm_reg);
    assign q_pos = 11'sd51 - $signed({5'd0, lz_r});
    assign eu    = rx_reg + q_pos;

    always_comb begin
        if (sh_reg <= 11'sd0) begin
            shu    = 6'(-sh_reg);
            mr     = 26'(rm_reg << shu);
            g_bit  = 1'b0;
            st_bit = 1'b0;
        end else if (sh_reg >= 11'sd53) begin
            shu    = 6'd0;
            mr     = '0;
            g_bit  = 1'b0;
            st_bit = (rm_reg != 52'd0);
        end else begin
            shu    = sh_reg[5:0];
            mr     = 26'(rm_reg >> shu);
            g_bit  = rm_reg[shu - 6'd1];
            st_bit = ((rm_reg & ((52'd1 << (shu - 6'd1)) - 52'd1)) != 52'd0);
        end
        mrr = mr + 26'(g_bit & (st_bit | mr[0]));
        tot = {eb_reg, 23'd0} + {8'd0, mrr};
        if (rm_reg == 52'd0) begin
            pack_bits = {rsg_reg, 31'd0};
        end else if (tot[33:23] >= 11'd255) begin
            pack_bits = {rsg_reg, 8'hFF, 23'd0};
        end else begin
            pack_bits = {rsg_reg, tot[30:0]};
        end
    end

    assign fin_idle = !last_reg;

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        ws_next    = ws_reg;
        as_next    = as_reg;
        last_next  = last_reg;
        scale_next = scale_reg;
        acc_next   = acc_reg;
        rm_next    = rm_reg;
        rx_next    = rx_reg;
        rsg_next   = rsg_reg;
        phase_next = phase_reg;
        sh_next    = sh_reg;
        eb_next    = eb_reg;
        mp_next    = mp_reg;
        ma_next    = ma_reg;
        ep_next    = ep_reg;
        tp_next    = tp_reg;
        ta_next    = ta_reg;
        sp_next    = sp_reg;
        pz_next    = pz_reg;
        az_next    = az_reg;
        xb_next    = xb_reg;
        xs_next    = xs_reg;
        tb_next    = tb_reg;
        bsg_next   = bsg_reg;
        sub_next   = sub_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    sum_next   = req.sum;
                    ws_next    = req.ws;
                    as_next    = req.as_bits;
                    last_next  = req.last;
                    state_next = ST_SMUL;
                end
            end
            ST_SMUL: begin
                if (h_nan || f_nan || (h_inf && f_zero) || (f_inf && h_zero)) begin
                    scale_next = F32_QNAN;
                    state_next = ST_PMUL;
                end else if (h_inf || f_inf) begin
                    scale_next = {ws_reg[15] ^ as_reg[31], 8'hFF, 23'd0};
                    state_next = ST_PMUL;
                end else begin
                    rm_next    = {17'd0, s_prod};
                    rx_next    = h_eff + f_eff - 11'sd175;
                    rsg_next   = ws_reg[15] ^ as_reg[31];
                    phase_next = 1'b0;
                    state_next = ST_RNORM;
                end
            end
            ST_RNORM: begin
                if (eu >= -11'sd126) begin
                    sh_next = q_pos - 11'sd23;
                    eb_next = eu + 11'sd126;
                end else begin
                    sh_next = -11'sd149 - rx_reg;
                    eb_next = 11'sd0;
                end
                state_next = ST_RPACK;
            end
            ST_RPACK: begin
                if (!phase_reg) begin
                    scale_next = pack_bits;
                    state_next = ST_PMUL;
                end else begin
                    acc_next   = pack_bits;
                    state_next = fin_idle ? ST_IDLE : ST_DONE;
                end
            end
            ST_PMUL: begin
                sp_next = sum_reg[FSUM_W-1] ^ scale_reg[31];
                if (c_nan || a_nan) begin
                    acc_next   = F32_QNAN;
                    state_next = fin_idle ? ST_IDLE : ST_DONE;
                end else if (c_inf) begin
                    if ((sum_reg == '0) || (a_inf && (acc_reg[31] != sp_next))) begin
                        acc_next = F32_QNAN;
                    end else begin
                        acc_next = {sp_next, 8'hFF, 23'd0};
                    end
                    state_next = fin_idle ? ST_IDLE : ST_DONE;
                end else if (a_inf) begin
                    state_next = fin_idle ? ST_IDLE : ST_DONE;
                end else begin
                    mp_next    = p_prod;
                    ep_next    = c_eff - 11'sd150;
                    pz_next    = (sum_reg == '0) || c_zero;
                    state_next = ST_PNORM;
                end
            end
            ST_PNORM: begin
                if (pz_reg) begin
                    // Zero product: keep the accumulator; both zero gives -0 only if both negative
                    if (a_zero) begin
                        acc_next = {sp_reg & acc_reg[31], 31'd0};
                    end
                    state_next = fin_idle ? ST_IDLE : ST_DONE;
                end else begin
                    mp_next    = mp_reg << lzp;
                    tp_next    = tp_calc;
                    ma_next    = a_sig48 << lza;
                    ta_next    = ta_calc;
                    az_next    = a_zero;
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                xb_next    = {1'b0, m_big, 3'd0};
                xs_next    = xs_calc;
                tb_next    = bigp ? tp_reg : ta_reg;
                bsg_next   = bigp ? sp_reg : acc_reg[31];
                sub_next   = sp_reg ^ acc_reg[31];
                state_next = ST_ADD;
            end
            ST_ADD: begin
                rm_next    = sub_reg ? (xb_reg - xs_reg) : (xb_reg + xs_reg);
                rx_next    = tb_reg - 11'sd50;
                rsg_next   = (rm_next == 52'd0) ? 1'b0 : bsg_reg;
                phase_next = 1'b1;
                state_next = ST_RNORM;
            end
            ST_DONE: begin
                if (res_take) begin
                    acc_next   = 32'd0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            acc_reg   <= 32'd0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk) begin
        sum_reg   <= sum_next;
        ws_reg    <= ws_next;
        as_reg    <= as_next;
        last_reg  <= last_next;
        scale_reg <= scale_next;
        rm_reg    <= rm_next;
        rx_reg    <= rx_next;
        rsg_reg   <= rsg_next;
        phase_reg <= phase_next;
        sh_reg    <= sh_next;
        eb_reg    <= eb_next;
        mp_reg    <= mp_next;
        ma_reg    <= ma_next;
        ep_reg    <= ep_next;
        tp_reg    <= tp_next;
        ta_reg    <= ta_next;
        sp_reg    <= sp_next;
        pz_reg    <= pz_next;
        az_reg    <= az_next;
        xb_reg    <= xb_next;
        xs_reg    <= xs_next;
        tb_reg    <= tb_next;
        bsg_reg   <= bsg_next;
        sub_reg   <= sub_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign res.valid = (state_reg == ST_DONE);
    assign res.data  = acc_reg;

endmodule

// ----- rtl/core/block_quantized_dot_product_top.sv -----
// Top level of the Q8_0/Q4_0 block-quantized dot-product engine.
//
// Usage: each input transfer (in_valid/in_ready) carries eight weight codes, eight int8
// activations, the fp16 weight scale and fp32 activation scale of the current block, and
// row_end on the last item of a row. One output transfer (out_valid/out_ready) carries the
// fp32 dot product of each row. cfg_we/cfg_wdata write the weight format (0 Q8_0, 1 Q4_0)
// while the block is idle.
// Items: items that do not close a block are taken back to back; the LANES lane multipliers
// and the merge adder feed the block sum register. After an item that closes a block (every
// BLOCK_ELEMS/LANES items, or on row_end) the float unit runs the scale product and the
// fused multiply-add through its one shared rounding stage, and in_ready stays low
// meanwhile. Special operands (inf, NaN, zero product) finish sooner.
// Path: row_end passes the merge request register, the float unit and the output register.
// Stall: a finished row result waits in the output register; the next row's items are
// still taken. Only a second row result stalls in the float unit until the register drains.
// Reset: clears the block sum, item count, accumulator (+0.0), output valid and selects Q8_0.
module block_quantized_dot_product_top #(
    parameter int BLOCK_ELEMS = 32,
    parameter int LANES       = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] weight_codes,
    input  logic [63:0] act_codes,
    input  logic [15:0] weight_scale,
    input  logic [31:0] act_scale,
    input  logic        row_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] dot_result
);
    import qdp_pkg::*;

    logic               weight_format_reg, weight_format_next;
    logic signed [15:0] lane_prod [LANES];
    logic               in_xfer;
    qdp_close_t         close_req;
    qdp_res_t           fpu_res;
    logic               fpu_busy;
    logic               out_take;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        dot_result_reg, dot_result_next;

    // Format register: the user must write it only while idle; the block does not enforce this
    assign weight_format_next = cfg_we ? cfg_wdata : weight_format_reg;

    // Hold input while the float unit works or a close request is pending
    assign in_ready = !fpu_busy && !close_req.start;
    assign in_xfer  = in_valid && in_ready;

    // Lanes: one signed product per element
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        qdp_lane u_lane (
            .fmt    (weight_format_reg),
            .w_code (weight_codes[8*l +: 8]),
            .a_code (act_codes[8*l +: 8]),
            .prod   (lane_prod[l])
        );
    end

    // Merge: add lane products into the block sum, close blocks
    qdp_merge #(
        .LANES       (LANES),
        .BLOCK_ELEMS (BLOCK_ELEMS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_xfer),
        .lane_prod    (lane_prod),
        .weight_scale (weight_scale),
        .act_scale    (act_scale),
        .row_end      (row_end),
        .req          (close_req)
    );

    // Float unit: scale product, fused multiply-add, row accumulator
    qdp_fpu u_fpu (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (close_req),
        .res_take (out_take),
        .busy     (fpu_busy),
        .res      (fpu_res)
    );

    // Output register: take a new row result when empty or draining this cycle
    assign out_take = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg && !out_ready;
        dot_result_next = dot_result_reg;
        if (fpu_res.valid && out_take) begin
            out_valid_next  = 1'b1;
            dot_result_next = fpu_res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            weight_format_reg <= FMT_Q8_0;
            out_valid_reg     <= 1'b0;
        end else begin
            weight_format_reg <= weight_format_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        dot_result_reg <= dot_result_next;
    end

    assign out_valid  = out_valid_reg;
    assign dot_result = dot_result_reg;

endmodule

// ----- rtl/core/qdp_checker.sv -----
// Port-level checker for the dot-product top level, with its bind.
module qdp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        row_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] dot_result
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dot_result))
        else $error("stalled result changed");

    // Any NaN result is the canonical quiet NaN
    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (dot_result[30:23] == 8'hFF) && (dot_result[22:0] != 23'd0)
        |-> dot_result == 32'h7FC0_0000)
        else $error("non-canonical NaN result");

    // A row end closes a block, so input is held in the next cycle
    a_row_end_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && row_end |=> !in_ready)
        else $error("input taken right after row end");

    // Coming out of reset no result is shown
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid after reset");

endmodule

bind block_quantized_dot_product_top qdp_checker u_qdp_checker (.*);
